// ===== rtl/eegcd_pkg.sv =====
// Shared types, widths and helpers for the extended Euclidean gcd block.
// No dependencies; every other file imports this package.
package eegcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic                         mode;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] gcd_value;
        logic signed [DATA_WIDTH-1:0] coef_x;
        logic signed [DATA_WIDTH-1:0] coef_y;
    } t_out_beat;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic  start;
        t_word num;
        t_word den;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quo;
        t_word rem;
    } t_div_rsp;

    function automatic t_word neg_w(input t_word v);
        return (~v) + t_word'(1);
    endfunction

    function automatic t_word mag_w(input t_word v);
        return v[DATA_WIDTH-1] ? neg_w(v) : v;
    endfunction

endpackage

// ===== rtl/eegcd_div.sv =====
// Unsigned shift-subtract divider shared by every Euclid step.
// Depends on eegcd_pkg. Aligns the divisor first, then restores one bit a cycle.
module eegcd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eegcd_pkg::t_div_req i_req,
    output eegcd_pkg::t_div_rsp o_rsp
);
    import eegcd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ALIGN, S_SUB} t_state;

    t_state           r_state, n_state;
    logic             r_done, n_done;
    t_word            r_rem, n_rem;
    t_word            r_dsh, n_dsh;
    t_word            r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [DATA_WIDTH:0] shl;
    logic                fits;
    logic                ge;
    t_word               diff;

    always_comb begin
        shl  = {r_dsh, 1'b0};
        fits = (shl <= {1'b0, r_rem});
        ge   = (r_rem >= r_dsh);
        diff = r_rem - r_dsh;

        n_state = r_state;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_rem   = i_req.num;
                    n_dsh   = i_req.den;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                // advance divisor until one more shift would pass the dividend
                if (!r_dsh[DATA_WIDTH-1] && fits) begin
                    n_dsh = shl[DATA_WIDTH-1:0];
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                n_quo = {r_quo[DATA_WIDTH-2:0], ge};
                if (ge) begin
                    n_rem = diff;
                end
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                    n_dsh = r_dsh >> 1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/extended_euclidean_gcd_top.sv =====
// Top level of the gcd / extended gcd block: step sequencer, coefficient multiplier,
// output register. Depends on eegcd_pkg and eegcd_div.
// Each Euclid step waits on the bit-a-cycle divider, then runs two multiply states (mode 1
// only) and the update state; an item is loaded from idle and retired from S_CHECK.
// A zero second operand skips the divider entirely; one item in flight.
// Reset: synchronous, active low; clears the sequencer and the output valid.
module extended_euclidean_gcd_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  eegcd_pkg::t_in_beat  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output eegcd_pkg::t_out_beat o_data
);
    import eegcd_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_MULS, S_MULT, S_UPD} t_state;

    t_state    r_state, n_state;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;
    logic      r_mode, n_mode;
    t_word     r_r0, n_r0, r_r1, n_r1;
    t_word     r_s0, n_s0, r_s1, n_s1;
    t_word     r_t0, n_t0, r_t1, n_t1;
    t_word     r_q, n_q, r_rem, n_rem, r_prod, n_prod;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    logic      in_beat;
    logic      out_free;
    logic      sign_diff;

    eegcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_beat   = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign sign_diff = r_r0[DATA_WIDTH-1] != r_r1[DATA_WIDTH-1];

    always_comb begin
        div_req.start = (r_state == S_CHECK) && (r_r1 != '0);
        div_req.num   = r_mode ? mag_w(r_r0) : r_r0;
        div_req.den   = r_mode ? mag_w(r_r1) : r_r1;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_mode      = r_mode;
        n_r0        = r_r0;
        n_r1        = r_r1;
        n_s0        = r_s0;
        n_s1        = r_s1;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_q         = r_q;
        n_rem       = r_rem;
        n_prod      = r_prod;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_mode  = i_data.mode;
                    n_r0    = i_data.mode ? t_word'(i_data.operand_a)
                                          : mag_w(t_word'(i_data.operand_a));
                    n_r1    = i_data.mode ? t_word'(i_data.operand_b)
                                          : mag_w(t_word'(i_data.operand_b));
                    n_s0    = t_word'(1);
                    n_s1    = '0;
                    n_t0    = '0;
                    n_t1    = t_word'(1);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_r1 != '0) begin
                    n_state = S_DIV;
                end else if (out_free) begin
                    // hold here until the output register can take the beat
                    n_out.gcd_value = r_r0;
                    n_out.coef_x    = r_mode ? r_s0 : '0;
                    n_out.coef_y    = r_mode ? r_t0 : '0;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    // truncating division: quotient sign from both, remainder from dividend
                    n_q     = (r_mode && sign_diff) ? neg_w(div_rsp.quo) : div_rsp.quo;
                    n_rem   = (r_mode && r_r0[DATA_WIDTH-1]) ? neg_w(div_rsp.rem)
                                                             : div_rsp.rem;
                    n_state = r_mode ? S_MULS : S_UPD;
                end
            end
            S_MULS: begin
                n_prod  = r_q * r_s1;
                n_state = S_MULT;
            end
            S_MULT: begin
                n_s0    = r_s1;
                n_s1    = r_s0 - r_prod;
                n_prod  = r_q * r_t1;
                n_state = S_UPD;
            end
            S_UPD: begin
                n_r0 = r_r1;
                n_r1 = r_rem;
                if (r_mode) begin
                    n_t0 = r_t1;
                    n_t1 = r_t0 - r_prod;
                end
                n_state = S_CHECK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_mode <= n_mode;
        r_r0   <= n_r0;
        r_r1   <= n_r1;
        r_s0   <= n_s0;
        r_s1   <= n_s1;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_prod <= n_prod;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_ready)
        else $error("input taken while an item is still in work");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the wait state");

    a_mode0_zero_coef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && r_r1 == '0 && out_free && !r_mode)
        |=> (o_valid && o_data.coef_x == '0 && o_data.coef_y == '0))
        else $error("plain gcd result carries nonzero coefficients");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for extended_euclidean_gcd_top: directed and random operand pairs
// in both modes, expected gcd and Bezout coefficients from a local predictor.
// Depends on eegcd_pkg and the RTL of the block.
module tb_top;
    import eegcd_pkg::*;

    localparam int W = DATA_WIDTH;

    // Expected gcd results in acceptance order, checked against every output beat.
    class gcd_scoreboard;
        t_out_beat   pending_gcds[$];
        int unsigned mismatches = 0;

        function t_word word_neg(input t_word v);
            return t_word'(0) - v;
        endfunction

        function t_word word_mag(input t_word v);
            return v[W-1] ? word_neg(v) : v;
        endfunction

        // Plain gcd of magnitudes, or the truncating extended recurrence, at W bits.
        function t_out_beat predict_gcd(input t_in_beat b);
            t_out_beat res;
            t_word     r0, r1, s0, s1, t0, t1;
            t_word     q, rem, ns, nt, mn, md;
            res = '0;
            if (!b.mode) begin
                r0 = word_mag(t_word'(b.operand_a));
                r1 = word_mag(t_word'(b.operand_b));
                while (r1 != '0) begin
                    rem = r0 % r1;
                    r0  = r1;
                    r1  = rem;
                end
                res.gcd_value = r0;
            end else begin
                r0 = t_word'(b.operand_a);
                r1 = t_word'(b.operand_b);
                s0 = t_word'(1);
                s1 = '0;
                t0 = '0;
                t1 = t_word'(1);
                while (r1 != '0) begin
                    mn  = word_mag(r0);
                    md  = word_mag(r1);
                    q   = mn / md;
                    rem = mn % md;
                    // quotient rounds toward zero, remainder follows the dividend
                    if (r0[W-1] != r1[W-1]) q = word_neg(q);
                    if (r0[W-1]) rem = word_neg(rem);
                    ns = s0 - q * s1;
                    nt = t0 - q * t1;
                    r0 = r1;
                    r1 = rem;
                    s0 = s1;
                    s1 = ns;
                    t0 = t1;
                    t1 = nt;
                end
                res.gcd_value = r0;
                res.coef_x    = s0;
                res.coef_y    = t0;
            end
            return res;
        endfunction

        function void note_input(input t_in_beat b);
            pending_gcds.push_back(predict_gcd(b));
        endfunction

        function void check_result(input t_out_beat got);
            t_out_beat exp_beat;
            if (pending_gcds.size() == 0) begin
                $error("result beat with nothing expected: gcd_value %0d", got.gcd_value);
                mismatches++;
                return;
            end
            exp_beat = pending_gcds.pop_front();
            if (got.gcd_value !== exp_beat.gcd_value) begin
                $error("gcd_value: expected %0d, got %0d", exp_beat.gcd_value, got.gcd_value);
                mismatches++;
            end
            if (got.coef_x !== exp_beat.coef_x) begin
                $error("coef_x: expected %0d, got %0d", exp_beat.coef_x, got.coef_x);
                mismatches++;
            end
            if (got.coef_y !== exp_beat.coef_y) begin
                $error("coef_y: expected %0d, got %0d", exp_beat.coef_y, got.coef_y);
                mismatches++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 400;

    localparam logic signed [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] FIB_46  = 32'sd1836311903;
    localparam logic signed [W-1:0] FIB_45  = 32'sd1134903170;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_beat  i_data  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_beat o_data;

    logic      hold_req = 1'b0;

    gcd_scoreboard sb = new();

    extended_euclidean_gcd_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Offer one beat and hold it until accepted; valid stays high on return.
    task automatic offer_beat(input logic m, input logic signed [W-1:0] a,
                              input logic signed [W-1:0] b);
        t_in_beat beat;
        beat.mode      = m;
        beat.operand_a = a;
        beat.operand_b = b;
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(beat);
    endtask

    // Drop valid and scramble the idle payload; n sets how long the sender stays quiet.
    task automatic idle_sender(input int n);
        i_valid <= 1'b0;
        i_data  <= $bits(t_in_beat)'({$urandom(), $urandom(), $urandom()});
        repeat (n) @(posedge i_clk);
    endtask

    // Receiver: stretches of varying ready patterns, plus one long hold-off.
    initial begin
        int kind, len, stall_phase;
        bit hold_done;
        stall_phase = 0;
        hold_done   = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            kind = $urandom_range(0, 3);
            len  = $urandom_range(20, 400);
            repeat (len) begin
                case (kind)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= (stall_phase % 4) == 0;
                    default: i_ready <= $urandom_range(0, 7) == 0;
                endcase
                stall_phase++;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    initial begin
        int        burst, kind, k;
        logic      m;
        int        g, ma, mb;
        longint    f0, f1, ft;
        logic signed [W-1:0] a, b;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zeros, extremes, long Fibonacci chains, most negative value.
        offer_beat(1'b0, 0, 0);
        offer_beat(1'b1, 0, 0);
        offer_beat(1'b1, 12345, 0);
        offer_beat(1'b1, -12345, 0);
        offer_beat(1'b0, -98765, 0);
        offer_beat(1'b1, 0, -7);
        offer_beat(1'b0, 0, -7);
        offer_beat(1'b1, MAX_POS, MAX_POS);
        offer_beat(1'b1, -MAX_POS, MAX_POS);
        offer_beat(1'b0, -MAX_POS, -MAX_POS);
        offer_beat(1'b1, MAX_POS, 1);
        offer_beat(1'b1, 1, -MAX_POS);
        offer_beat(1'b0, MAX_POS, MAX_POS - 1);
        offer_beat(1'b1, FIB_46, FIB_45);
        offer_beat(1'b0, FIB_46, FIB_45);
        offer_beat(1'b1, -FIB_46, FIB_45);
        offer_beat(1'b1, FIB_45, -FIB_46);
        offer_beat(1'b1, 240, -46);
        offer_beat(1'b1, -240, -46);
        offer_beat(1'b1, MIN_NEG, 0);
        offer_beat(1'b0, MIN_NEG, 0);
        offer_beat(1'b1, MIN_NEG, 6);
        offer_beat(1'b0, MIN_NEG, MIN_NEG);

        hold_req <= 1'b1;
        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            m    = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    a = $urandom();
                    b = $urandom();
                end
                4, 5: begin
                    a = $urandom_range(0, 1000);
                    b = $urandom_range(0, 1000);
                    if ($urandom_range(0, 1)) a = -a;
                    if ($urandom_range(0, 1)) b = -b;
                end
                6, 7: begin
                    // shared factor so the gcd is not trivially one
                    g  = $urandom_range(1, 1000);
                    ma = $urandom_range(0, 1000000);
                    mb = $urandom_range(0, 1000000);
                    a  = g * ma;
                    b  = g * mb;
                    if ($urandom_range(0, 1)) a = -a;
                    if ($urandom_range(0, 1)) b = -b;
                end
                8: begin
                    a = $urandom();
                    case ($urandom_range(0, 2))
                        0: b = 0;
                        1: begin b = a; a = 0; end
                        default: b = $urandom_range(0, 1) ? a : -a;
                    endcase
                end
                default: begin
                    // consecutive Fibonacci numbers give the longest chains
                    k  = $urandom_range(1, 44);
                    f0 = 1;
                    f1 = 1;
                    repeat (k) begin
                        ft = f0 + f1;
                        f0 = f1;
                        f1 = ft;
                    end
                    a = W'(f1);
                    b = W'(f0);
                    if ($urandom_range(0, 1)) a = -a;
                    if ($urandom_range(0, 1)) b = -b;
                end
            endcase
            if (a == MIN_NEG) a = MAX_POS;
            if (b == MIN_NEG) b = -MAX_POS;
            offer_beat(m, a, b);
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 30));
            end else begin
                burst--;
            end
        end
        i_valid <= 1'b0;

        while (sb.pending_gcds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/eegcd_pkg.sv
rtl/eegcd_div.sv
rtl/extended_euclidean_gcd_top.sv
sim/tb_top.sv
